// ===== src/voice_resampler_iir_filter_defines.svh =====
// Assertion macros shared by the voice resampler RTL.
// Depends on nothing; a module that uses them needs clk and arst_n in scope.
`ifndef VOICE_RESAMPLER_IIR_FILTER_DEFINES_SVH
`define VOICE_RESAMPLER_IIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define VRIF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("vrif assertion failed");
`define VRIF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vrif implication failed");
`else
`define VRIF_ASSERT(label, prop)
`define VRIF_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== src/vrif_pkg.sv =====
// Shared types, constants and helpers for the voice resampler.
// Used by the front queue, configuration block, filter engine and top level.
package vrif_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int PITCH_W     = 16;
	localparam int FRAC_BITS   = 12;
	localparam int FRAC_ONE    = 1 << FRAC_BITS;
	localparam int FRAC_W      = PITCH_W + 1;
	localparam int MAX_OUT     = 64;
	localparam int CNT_W       = $clog2(MAX_OUT + 1);
	localparam int MIN_PITCH   = 64;
	localparam int LP_SHIFT    = 7;
	localparam int IIR_SHIFT   = 15;
	localparam int MUL_W       = SAMPLE_W + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W + 2;
	localparam int WIDE_W      = PROD_W + 2;
	localparam int ADDR_W      = 5;
	localparam int REG_IDX_W   = 3;
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PITCH_RESET = 4096;

	localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(32767);
	localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(32768);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PITCH    = 3'd0,
		REG_LP_COEFF = 3'd1,
		REG_BQ_EN    = 3'd2,
		REG_COEF_B1  = 3'd3,
		REG_COEF_B2  = 3'd4,
		REG_COEF_A1  = 3'd5,
		REG_COEF_A2  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PITCH_W-1:0]         pitch;
		logic signed [SAMPLE_W-1:0] lp_coeff;
		logic                       biquad_enable;
		logic signed [SAMPLE_W-1:0] coef_b1;
		logic signed [SAMPLE_W-1:0] coef_b2;
		logic signed [SAMPLE_W-1:0] coef_a1;
		logic signed [SAMPLE_W-1:0] coef_a2;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} queue_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INTERP_MUL,
		ST_INTERP_ADD,
		ST_LP_MUL,
		ST_LP_ADD,
		ST_IIR_MUL,
		ST_IIR_SUM,
		ST_EMIT,
		ST_FINISH
	} eng_state_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] x);
		logic signed [SAMPLE_W-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[SAMPLE_W-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[SAMPLE_W-1:0];
		end else begin
			r = x[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/vrif_front.sv =====
// Front end: accepts source words and holds them in a two-entry queue.
// Depends on vrif_pkg for the queue word type.
module vrif_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [vrif_pkg::SAMPLE_W-1:0] source_sample,
	input  logic                                 restart,
	output logic                                 q_valid,
	output vrif_pkg::queue_word_t                q_word,
	input  logic                                 q_pop
);
	import vrif_pkg::*;

	queue_word_t        ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_word   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{sample: source_sample, restart: restart};
		end
	end

endmodule

// ===== src/vrif_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on vrif_pkg for the register map and the config struct.
module vrif_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vrif_pkg::ADDR_W-1:0]  paddr,
	input  logic [vrif_pkg::DATA_W-1:0]  pwdata,
	output logic [vrif_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output vrif_pkg::cfg_t               cfg
);
	import vrif_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				pitch:         PITCH_W'(PITCH_RESET),
				lp_coeff:      '0,
				biquad_enable: 1'b0,
				coef_b1:       '0,
				coef_b2:       '0,
				coef_a1:       '0,
				coef_a2:       '0
			};
		end else if (wr_en) begin
			unique case (idx)
				REG_PITCH:    cfg_q.pitch         <= pwdata[PITCH_W-1:0];
				REG_LP_COEFF: cfg_q.lp_coeff      <= $signed(pwdata[SAMPLE_W-1:0]);
				REG_BQ_EN:    cfg_q.biquad_enable <= pwdata[0];
				REG_COEF_B1:  cfg_q.coef_b1       <= $signed(pwdata[SAMPLE_W-1:0]);
				REG_COEF_B2:  cfg_q.coef_b2       <= $signed(pwdata[SAMPLE_W-1:0]);
				REG_COEF_A1:  cfg_q.coef_a1       <= $signed(pwdata[SAMPLE_W-1:0]);
				REG_COEF_A2:  cfg_q.coef_a2       <= $signed(pwdata[SAMPLE_W-1:0]);
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PITCH:    prdata = DATA_W'(cfg_q.pitch);
			REG_LP_COEFF: prdata = DATA_W'(cfg_q.lp_coeff);
			REG_BQ_EN:    prdata = DATA_W'(cfg_q.biquad_enable);
			REG_COEF_B1:  prdata = DATA_W'(cfg_q.coef_b1);
			REG_COEF_B2:  prdata = DATA_W'(cfg_q.coef_b2);
			REG_COEF_A1:  prdata = DATA_W'(cfg_q.coef_a1);
			REG_COEF_A2:  prdata = DATA_W'(cfg_q.coef_a2);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== src/vrif_core.sv =====
// Back end: interpolator, first-order and four-tap IIR sections on one shared
// multiplier, sequenced per output word. Depends on vrif_pkg and the defines header.
`include "voice_resampler_iir_filter_defines.svh"

module vrif_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vrif_pkg::cfg_t                       cfg,
	input  logic                                 q_valid,
	input  vrif_pkg::queue_word_t                q_word,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [vrif_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                 last_of_run
);
	import vrif_pkg::*;

	eng_state_t                 state_q, state_d;
	logic signed [SAMPLE_W-1:0] older_q, newer_q;
	logic [FRAC_W-1:0]          frac_q;
	logic [CNT_W-1:0]           n_q;
	logic signed [SAMPLE_W-1:0] lp_in_q, lp_out_q;
	logic signed [SAMPLE_W-1:0] iir_in1_q, iir_in2_q, iir_out1_q, iir_out2_q;
	logic [1:0]                 tap_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       last_q;

	logic [PITCH_W-1:0]         step;
	logic [FRAC_W-1:0]          frac_next;
	logic                       is_last;
	logic                       emit_fire;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   product;
	logic signed [WIDE_W-1:0]   interp_w, lp_w, iir_w;
	logic signed [ACC_W-1:0]    iir_total;
	logic signed [SAMPLE_W-1:0] interp_sat, lp_sat, iir_sat;

	assign step      = (cfg.pitch < PITCH_W'(MIN_PITCH)) ? PITCH_W'(MIN_PITCH) : cfg.pitch;
	assign frac_next = frac_q + FRAC_W'(step);
	assign is_last   = (frac_next >= FRAC_W'(FRAC_ONE)) || (n_q == CNT_W'(MAX_OUT - 1));
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_INTERP_MUL: begin
				mul_a = MUL_W'(newer_q) - MUL_W'(older_q);
				mul_b = $signed({{(MUL_W-FRAC_BITS){1'b0}}, frac_q[FRAC_BITS-1:0]});
			end
			ST_LP_MUL: begin
				mul_a = MUL_W'(samp_q) - MUL_W'(lp_in_q);
				mul_b = MUL_W'(cfg.lp_coeff);
			end
			ST_IIR_MUL: begin
				case (tap_q)
					2'd0: begin
						mul_a = MUL_W'(cfg.coef_b1);
						mul_b = MUL_W'(iir_in1_q);
					end
					2'd1: begin
						mul_a = MUL_W'(cfg.coef_b2);
						mul_b = MUL_W'(iir_in2_q);
					end
					2'd2: begin
						mul_a = MUL_W'(cfg.coef_a1);
						mul_b = MUL_W'(iir_out1_q);
					end
					default: begin
						mul_a = MUL_W'(cfg.coef_a2);
						mul_b = MUL_W'(iir_out2_q);
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product    = mul_a * mul_b;
	assign interp_w   = WIDE_W'(prod_q >>> FRAC_BITS) + WIDE_W'(older_q);
	assign lp_w       = WIDE_W'(prod_q >>> LP_SHIFT) + WIDE_W'(lp_out_q);
	assign iir_total  = acc_q + ACC_W'(prod_q);
	assign iir_w      = WIDE_W'(iir_total >>> IIR_SHIFT);
	assign interp_sat = sat16(interp_w);
	assign lp_sat     = sat16(lp_w);
	assign iir_sat    = sat16(iir_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (frac_q < FRAC_W'(FRAC_ONE) && n_q < CNT_W'(MAX_OUT)) begin
					state_d = ST_INTERP_MUL;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_INTERP_MUL: state_d = ST_INTERP_ADD;
			ST_INTERP_ADD: begin
				if (cfg.lp_coeff != '0) begin
					state_d = ST_LP_MUL;
				end else if (cfg.biquad_enable) begin
					state_d = ST_IIR_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_LP_MUL: state_d = ST_LP_ADD;
			ST_LP_ADD: state_d = cfg.biquad_enable ? ST_IIR_MUL : ST_EMIT;
			ST_IIR_MUL: begin
				if (tap_q == 2'd3) state_d = ST_IIR_SUM;
			end
			ST_IIR_SUM: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_fire) state_d = ST_CHECK;
			end
			ST_FINISH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q     <= '0;
			newer_q     <= '0;
			frac_q      <= '0;
			n_q         <= '0;
			lp_in_q     <= '0;
			lp_out_q    <= '0;
			iir_in1_q   <= '0;
			iir_in2_q   <= '0;
			iir_out1_q  <= '0;
			iir_out2_q  <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_word.restart) begin
							older_q    <= '0;
							frac_q     <= '0;
							lp_in_q    <= '0;
							lp_out_q   <= '0;
							iir_in1_q  <= '0;
							iir_in2_q  <= '0;
							iir_out1_q <= '0;
							iir_out2_q <= '0;
						end
						newer_q <= q_word.sample;
						n_q     <= '0;
					end
				end
				ST_INTERP_ADD: tap_q <= '0;
				ST_LP_ADD: begin
					lp_in_q  <= samp_q;
					lp_out_q <= lp_sat;
					tap_q    <= '0;
				end
				ST_IIR_MUL: tap_q <= tap_q + 1'b1;
				ST_IIR_SUM: begin
					iir_in2_q  <= iir_in1_q;
					iir_in1_q  <= samp_q;
					iir_out2_q <= iir_out1_q;
					iir_out1_q <= iir_sat;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						frac_q <= frac_next;
						n_q    <= n_q + 1'b1;
					end
				end
				ST_FINISH: begin
					frac_q  <= (frac_q >= FRAC_W'(FRAC_ONE)) ? frac_q - FRAC_W'(FRAC_ONE) : '0;
					older_q <= newer_q;
				end
				default: ;
			endcase

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= product;
		case (state_q)
			ST_INTERP_ADD: begin
				samp_q <= interp_sat;
				acc_q  <= '0;
			end
			ST_LP_ADD: begin
				samp_q <= lp_sat;
				acc_q  <= '0;
			end
			ST_IIR_MUL: begin
				if (tap_q != 2'd0) acc_q <= iir_total;
			end
			ST_IIR_SUM: samp_q <= iir_sat;
			default: ;
		endcase
		if (emit_fire) begin
			out_sample_q <= samp_q;
			last_q       <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_q;

	`VRIF_ASSERT(a_count_bound, n_q <= CNT_W'(MAX_OUT))
	`VRIF_ASSERT_IMPL(a_interp_frac, state_q == ST_INTERP_MUL, frac_q < FRAC_W'(FRAC_ONE))
	`VRIF_ASSERT_IMPL(a_pop_idle, q_pop, state_q == ST_IDLE && state_d == ST_CHECK)
	`VRIF_ASSERT(a_last_ends_run, emit_fire && is_last |=> state_q == ST_CHECK ##1 state_q == ST_FINISH)

endmodule

// ===== src/voice_resampler_iir_filter.sv =====
// Voice resampler: linear interpolation followed by a first-order section and
// a four-tap IIR section, each optional and saturating to 16 bits.
//
// Input channel (in_valid / in_stall, source_sample, restart): a word is taken
// when in_valid is high and in_stall low. A two-word queue sits in front of the
// engine, so the source may run ahead by two words while outputs drain.
// Output channel (out_valid / out_stall, out_sample, last_of_run): each input
// word yields zero to 64 output words; last_of_run marks the final one.
// The output register holds its word while out_stall is high, and the engine
// waits with the next word computed until the register frees up.
// Datapath: one shared 17x17 multiplier serves every product. Per output the engine
// interpolates, runs the first-order section if lp_coeff is nonzero and the IIR
// section (one product per tap) if biquad_enable is set, then emits the word. It
// takes a new input word only after the current one. Reset (arst_n low) clears
// history, position and the queue and loads pitch with 4096 and every other config
// register with zero. A word with restart set clears the history before it is used.
// The user must write registers over the APB port only while idle (not enforced).
module voice_resampler_iir_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [vrif_pkg::SAMPLE_W-1:0] source_sample,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [vrif_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                 last_of_run,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vrif_pkg::ADDR_W-1:0]          paddr,
	input  logic [vrif_pkg::DATA_W-1:0]          pwdata,
	output logic [vrif_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);
	import vrif_pkg::*;

	cfg_t        cfg;
	logic        q_valid;
	queue_word_t q_word;
	logic        q_pop;

	vrif_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vrif_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.source_sample (source_sample),
		.restart       (restart),
		.q_valid       (q_valid),
		.q_word        (q_word),
		.q_pop         (q_pop)
	);

	vrif_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_word      (q_word),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sample  (out_sample),
		.last_of_run (last_of_run)
	);

endmodule
